>>> src/sft_pkg.sv
// ----------------------------------------------------------------------------
// sft_pkg
// Shared widths and constants of the top-three syscall frequency tracker.
// ----------------------------------------------------------------------------
package sft_pkg;

  localparam int NUM_IDS = 512;
  localparam int ID_W    = 9;
  localparam int CNT_W   = 32;
  localparam int DLY_W   = 64;
  localparam int PID_W   = 22;
  localparam int ADDR_W  = $clog2(NUM_IDS);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Histogram address of an identifier; only meaningful for identifiers below NUM_IDS.
  function automatic logic [ADDR_W-1:0] addr_of(input logic [ID_W-1:0] id);
    logic [31:0] ext;
    ext = 32'(id);
    return ext[ADDR_W-1:0];
  endfunction

endpackage

>>> src/sft_ram.sv
// ----------------------------------------------------------------------------
// sft_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module sft_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/sft_div.sv
// ----------------------------------------------------------------------------
// sft_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// A zero divisor yields a zero quotient.
// ----------------------------------------------------------------------------
module sft_div import sft_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DLY_W-1:0] dividend,
  input  logic [DLY_W-1:0] divisor,
  output logic             busy,
  output logic [DLY_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DLY_W);

  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic [DLY_W-1:0]  quo_r;
  logic [DLY_W-1:0]  rem_r;
  logic [DLY_W-1:0]  dvs_r;
  logic              zero_r;
  logic [DLY_W:0]    rem_sh;
  logic [DLY_W:0]    rem_sub;
  logic              fits;

  assign rem_sh  = {rem_r, quo_r[DLY_W-1]};
  assign fits    = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
      quo_r  <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
      zero_r <= (divisor == '0);
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_sub[DLY_W-1:0];
      end else begin
        rem_r <= rem_sh[DLY_W-1:0];
      end
      quo_r  <= {quo_r[DLY_W-2:0], fits};
      step_r <= step_r + STEP_W'(1);
      if (step_r == STEP_W'(DLY_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy     = busy_r;
  assign quotient = zero_r ? '0 : quo_r;

endmodule

>>> src/syscall_top3_frequency_tracker.sv
// ----------------------------------------------------------------------------
// syscall_top3_frequency_tracker
// Counts syscall identifiers in a histogram memory, keeps a top-three ranking
// and, at the close of each event, reports the leaders and delay statistics.
// ----------------------------------------------------------------------------
// A beat without last_of_event is handled as a histogram read, then an update.
// A closing beat passes the update state, then waits in the divide state for
// the 64-bit radix-2 divider that forms the average delay and for a free
// result register before it is loaded there; no beat is taken meanwhile.
// After reset the histogram memory is cleared one entry a cycle, all NUM_IDS
// entries (512), before the first input beat is taken.
// ----------------------------------------------------------------------------
module syscall_top3_frequency_tracker import sft_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ID_W-1:0]  in_syscall_id,
  input  logic             in_last_of_event,
  input  logic [DLY_W-1:0] in_event_delay_sum,
  input  logic [DLY_W-1:0] in_event_delay_max,
  input  logic [PID_W-1:0] in_process_id,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ID_W-1:0]  out_first_id,
  output logic [CNT_W-1:0] out_first_count,
  output logic [ID_W-1:0]  out_second_id,
  output logic [CNT_W-1:0] out_second_count,
  output logic [ID_W-1:0]  out_third_id,
  output logic [CNT_W-1:0] out_third_count,
  output logic [DLY_W-1:0] out_average_delay,
  output logic [DLY_W-1:0] out_largest_delay,
  output logic [PID_W-1:0] out_result_process_id
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPD,
    S_DIV
  } state_t;

  state_t            state_r;
  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_addr_r;

  logic [ID_W-1:0]   id_r;
  logic [ADDR_W-1:0] addr_r;
  logic              in_range_r;
  logic              last_r;
  logic [DLY_W-1:0]  dsum_r;
  logic [DLY_W-1:0]  dmax_r;
  logic [PID_W-1:0]  pid_r;

  logic [ID_W-1:0]   lid_r   [3];
  logic [CNT_W-1:0]  lcnt_r  [3];
  logic [ID_W-1:0]   lid_nxt [3];
  logic [CNT_W-1:0]  lcnt_nxt[3];

  logic [DLY_W-1:0]  dly_total_r;
  logic [DLY_W-1:0]  sys_total_r;
  logic [DLY_W-1:0]  peak_r;
  logic [DLY_W-1:0]  dly_total_nxt;
  logic [DLY_W-1:0]  sys_total_nxt;
  logic [DLY_W-1:0]  peak_nxt;
  logic [DLY_W:0]    dly_sum;

  logic              out_valid_r;
  logic              accept;
  logic              out_load;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CNT_W-1:0]  ram_wdata;
  logic [CNT_W-1:0]  ram_rdata;
  logic [CNT_W-1:0]  cnt_inc;

  logic              div_start;
  logic              div_busy;
  logic [DLY_W-1:0]  div_quo;

  sft_ram #(
    .WIDTH(CNT_W),
    .DEPTH(NUM_IDS)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(addr_of(in_syscall_id)),
    .rdata(ram_rdata)
  );

  sft_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(dly_total_nxt),
    .divisor (sys_total_nxt),
    .busy    (div_busy),
    .quotient(div_quo)
  );

  assign in_stall  = (state_r != S_IDLE) || clr_busy_r;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_load  = (state_r == S_DIV) && !div_busy && (!out_valid_r || !out_stall);
  assign div_start = (state_r == S_UPD) && last_r;
  assign cnt_inc   = (ram_rdata == CNT_MAX) ? ram_rdata : ram_rdata + CNT_W'(1);

  always_comb begin
    if (clr_busy_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = (state_r == S_UPD) && in_range_r;
      ram_waddr = addr_r;
      ram_wdata = cnt_inc;
    end
  end

  always_comb begin
    logic             hit;
    logic [ID_W-1:0]  tid;
    logic [CNT_W-1:0] tcnt;
    hit      = 1'b0;
    tid      = '0;
    tcnt     = '0;
    lid_nxt  = lid_r;
    lcnt_nxt = lcnt_r;
    for (int k = 0; k < 3; k++) begin
      if (lid_r[k] == id_r) begin
        hit         = 1'b1;
        lcnt_nxt[k] = cnt_inc;
      end
    end
    if (hit) begin
      if (lcnt_nxt[2] > lcnt_nxt[1]) begin
        tid = lid_nxt[1];  tcnt = lcnt_nxt[1];
        lid_nxt[1] = lid_nxt[2];  lcnt_nxt[1] = lcnt_nxt[2];
        lid_nxt[2] = tid;         lcnt_nxt[2] = tcnt;
      end
      if (lcnt_nxt[1] > lcnt_nxt[0]) begin
        tid = lid_nxt[0];  tcnt = lcnt_nxt[0];
        lid_nxt[0] = lid_nxt[1];  lcnt_nxt[0] = lcnt_nxt[1];
        lid_nxt[1] = tid;         lcnt_nxt[1] = tcnt;
      end
      if (lcnt_nxt[2] > lcnt_nxt[1]) begin
        tid = lid_nxt[1];  tcnt = lcnt_nxt[1];
        lid_nxt[1] = lid_nxt[2];  lcnt_nxt[1] = lcnt_nxt[2];
        lid_nxt[2] = tid;         lcnt_nxt[2] = tcnt;
      end
    end else if (cnt_inc > lcnt_r[2]) begin
      if (cnt_inc > lcnt_r[1]) begin
        lid_nxt[2]  = lid_r[1];
        lcnt_nxt[2] = lcnt_r[1];
        if (cnt_inc > lcnt_r[0]) begin
          lid_nxt[1]  = lid_r[0];
          lcnt_nxt[1] = lcnt_r[0];
          lid_nxt[0]  = id_r;
          lcnt_nxt[0] = cnt_inc;
        end else begin
          lid_nxt[1]  = id_r;
          lcnt_nxt[1] = cnt_inc;
        end
      end else begin
        lid_nxt[2]  = id_r;
        lcnt_nxt[2] = cnt_inc;
      end
    end
  end

  always_comb begin
    sys_total_nxt = (sys_total_r == '1) ? sys_total_r : sys_total_r + DLY_W'(1);
    dly_sum       = {1'b0, dly_total_r} + {1'b0, dsum_r};
    dly_total_nxt = dly_sum[DLY_W] ? '1 : dly_sum[DLY_W-1:0];
    peak_nxt      = (dmax_r > peak_r) ? dmax_r : peak_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      dly_total_r <= '0;
      sys_total_r <= '0;
      peak_r      <= '0;
      for (int k = 0; k < 3; k++) begin
        lid_r[k]  <= '0;
        lcnt_r[k] <= '0;
      end
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(NUM_IDS - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end

      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            id_r       <= in_syscall_id;
            addr_r     <= addr_of(in_syscall_id);
            in_range_r <= 32'(in_syscall_id) < 32'(NUM_IDS);
            last_r     <= in_last_of_event;
            dsum_r     <= in_event_delay_sum;
            dmax_r     <= in_event_delay_max;
            pid_r      <= in_process_id;
            state_r    <= S_UPD;
          end
        end
        S_UPD: begin
          if (in_range_r) begin
            lid_r  <= lid_nxt;
            lcnt_r <= lcnt_nxt;
          end
          sys_total_r <= sys_total_nxt;
          if (last_r) begin
            dly_total_r <= dly_total_nxt;
            peak_r      <= peak_nxt;
            state_r     <= S_DIV;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_DIV: begin
          if (out_load) begin
            out_valid_r           <= 1'b1;
            out_first_id          <= lid_r[0];
            out_first_count       <= lcnt_r[0];
            out_second_id         <= lid_r[1];
            out_second_count      <= lcnt_r[1];
            out_third_id          <= lid_r[2];
            out_third_count       <= lcnt_r[2];
            out_average_delay     <= div_quo;
            out_largest_delay     <= peak_r;
            out_result_process_id <= pid_r;
            state_r               <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
